// ----- rtl/lu_linear_solver_assert.svh -----
// assertion macros used by the solver checker
// no dependencies
`ifndef LU_LINEAR_SOLVER_ASSERT_SVH
`define LU_LINEAR_SOLVER_ASSERT_SVH

// implication checked in the same cycle
`define LU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lu solver check failed");

// implication checked in the next cycle
`define LU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lu solver check failed");

`endif

// ----- rtl/lu_pkg.sv -----
// constants, types and fixed-point helpers of the lu solver
// no dependencies
`default_nettype none
package lu_pkg;

  localparam int unsigned NW = 4;

  localparam logic [1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [1:0] OP_LOAD_RHS  = 2'd1;
  localparam logic [1:0] OP_SOLVE     = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'(Q_MAX);
    lo = 64'(Q_MIN);
    if (v > hi) return Q_MAX;
    if (v < lo) return Q_MIN;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lu_if.sv -----
// channel interfaces of the lu solver: config, input beat, result beat
// no dependencies
`default_nettype none
interface lu_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface lu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [2:0]         row;
  logic [2:0]         column;
  logic signed [31:0] element_value;
  modport source (output valid, operation, row, column, element_value, input ready);
  modport sink (input valid, operation, row, column, element_value, output ready);
endinterface

interface lu_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         solution_index;
  logic signed [31:0] solution_value;
  logic               singular;
  logic               last_result;
  modport source (output valid, solution_index, solution_value, singular, last_result,
                  input ready);
  modport sink (input valid, solution_index, solution_value, singular, last_result,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/lu_mac.sv -----
// shared fixed-point multiplier with registered, floored and saturated product
// depends on lu_pkg
`default_nettype none
module lu_mac import lu_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [31:0]      prod_o
);
  logic signed [63:0] full;
  logic signed [63:0] shifted;
  logic signed [31:0] prod_q;

  assign full    = a_i * b_i;
  assign shifted = full >>> 16;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= sat32(shifted);
    end
  end

  assign prod_o = prod_q;
endmodule
`default_nettype wire

// ----- rtl/lu_div.sv -----
// serial q16.16 divider, one quotient bit a cycle, truncating and saturating
// depends on lu_pkg
`default_nettype none
module lu_div import lu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t  rsp_o
);
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic [32:0] trial;
  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic signed [31:0] res;

  assign num_mag = req_i.num[31] ? 32'(-req_i.num) : 32'(req_i.num);
  assign den_mag = req_i.den[31] ? 32'(-req_i.den) : 32'(req_i.den);
  assign trial   = {rem_q, quo_q[47]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd48;
      rem_d  = '0;
      quo_d  = {num_mag, 16'h0000};
      den_d  = den_mag;
      neg_d  = req_i.num[31] ^ req_i.den[31];
      zero_d = (req_i.den == '0);
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 32'(trial - {1'b0, den_q});
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  always_comb begin
    if (zero_q) begin
      res = '0;
    end else if (neg_q) begin
      res = (quo_q > 48'h0000_8000_0000) ? Q_MIN : 32'(-quo_q[31:0]);
    end else begin
      res = (quo_q > 48'h0000_7fff_ffff) ? Q_MAX : quo_q[31:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = res;
endmodule
`default_nettype wire

// ----- rtl/lu_linear_solver.sv -----
// lu solver top: sequencer, matrix and vector stores, result register
// depends on lu_pkg, lu_if, lu_mac, lu_div
// a solve does about n^3/3 + n^2 multiply-accumulates and n^2/2 + n/2 divisions, then
// emits n result beats, one per cycle while out_o.ready is high; no input beat is
// taken until the last result beat
// reset clears control and sets matrix_size to 3; the stores hold no reset value
`default_nettype none
module lu_linear_solver import lu_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lu_cfg_if.sink     cfg_i,
  lu_in_if.sink      in_i,
  lu_out_if.source   out_o
);
  localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CAP   = (MAX_DIM < 8) ? MAX_DIM : 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [1:0] K_UP  = 2'd0;
  localparam logic [1:0] K_LO  = 2'd1;
  localparam logic [1:0] K_FWD = 2'd2;
  localparam logic [1:0] K_BWD = 2'd3;

  function automatic logic [AW-1:0] mat_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
  endfunction

  logic [3:0]    state_q, state_d;
  logic [1:0]    kind_q, kind_d;
  logic [NW-1:0] i_q, i_d, k_q, k_d, j_q, j_d, n_q, n_d, e_q, e_d;
  logic [3:0]    size_q, size_d;
  logic          sing_q, sing_d;
  logic signed [31:0] acc_q, acc_d;

  logic signed [31:0] coef_mem [DEPTH];
  logic signed [31:0] lu_mem [DEPTH];
  logic signed [31:0] rhs_r [MAX_DIM];
  logic signed [31:0] vec_r [MAX_DIM];
  logic signed [31:0] diag_r [MAX_DIM];
  logic signed [31:0] coef_rd_q, lu_a_q, lu_b_q;

  logic [AW-1:0] coef_ra, lu_ra, lu_rb, lu_wa;
  logic          lu_we;
  logic signed [31:0] lu_wd;
  logic          vec_we, diag_we;
  logic signed [31:0] vec_wd;

  logic          in_fire, up_lo;
  logic [NW-1:0] n_act, j_nx;
  logic signed [31:0] prod, mac_b, fin_val;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign up_lo       = (kind_q == K_UP) || (kind_q == K_LO);

  always_comb begin
    if (size_q == 4'd0) begin
      n_act = NW'(1);
    end else if (32'(size_q) > CAP) begin
      n_act = NW'(CAP);
    end else begin
      n_act = NW'(size_q);
    end
  end

  always_comb begin
    case (kind_q)
      K_UP: begin
        lu_ra   = mat_addr(i_q, j_q);
        lu_rb   = mat_addr(j_q, k_q);
        coef_ra = mat_addr(i_q, k_q);
      end
      K_LO: begin
        lu_ra   = mat_addr(k_q, j_q);
        lu_rb   = mat_addr(j_q, i_q);
        coef_ra = mat_addr(k_q, i_q);
      end
      default: begin
        lu_ra   = mat_addr(i_q, j_q);
        lu_rb   = mat_addr(i_q, j_q);
        coef_ra = mat_addr(i_q, k_q);
      end
    endcase
  end

  assign mac_b   = up_lo ? lu_b_q : vec_r[IW'(j_q)];
  assign fin_val = sat32(64'(coef_rd_q) - 64'(acc_q));
  assign j_nx    = j_q + NW'(1);

  lu_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (state_q == S_MUL),
    .a_i    (lu_a_q),
    .b_i    (mac_b),
    .prod_o (prod)
  );

  assign div_req.start = (state_q == S_FIN) && ((kind_q == K_LO) || (kind_q == K_BWD));
  assign div_req.num   = (kind_q == K_LO) ? fin_val : acc_q;
  assign div_req.den   = diag_r[IW'(i_q)];

  lu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    i_d     = i_q;
    k_d     = k_q;
    j_d     = j_q;
    n_d     = n_q;
    e_d     = e_q;
    sing_d  = sing_q;
    acc_d   = acc_q;
    size_d  = size_q;
    lu_we   = 1'b0;
    lu_wa   = mat_addr(i_q, k_q);
    lu_wd   = fin_val;
    vec_we  = 1'b0;
    vec_wd  = acc_q;
    diag_we = 1'b0;
    if (cfg_i.valid && cfg_i.ready) begin
      size_d = cfg_i.data;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_i.operation == OP_SOLVE)) begin
          n_d     = n_act;
          kind_d  = K_UP;
          i_d     = '0;
          k_d     = '0;
          sing_d  = 1'b0;
          state_d = S_START;
        end
      end
      S_START: begin
        case (kind_q)
          K_FWD:   acc_d = rhs_r[IW'(i_q)];
          K_BWD:   acc_d = vec_r[IW'(i_q)];
          default: acc_d = '0;
        endcase
        if (kind_q == K_BWD) begin
          j_d     = i_q + NW'(1);
          state_d = ((i_q + NW'(1)) < n_q) ? S_RD : S_FIN;
        end else begin
          j_d     = '0;
          state_d = (i_q != '0) ? S_RD : S_FIN;
        end
      end
      S_RD: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = up_lo ? sat32(64'(acc_q) + 64'(prod)) : sat32(64'(acc_q) - 64'(prod));
        j_d   = j_nx;
        if (kind_q == K_BWD) begin
          state_d = (j_nx < n_q) ? S_RD : S_FIN;
        end else begin
          state_d = (j_nx < i_q) ? S_RD : S_FIN;
        end
      end
      S_FIN: begin
        case (kind_q)
          K_UP: begin
            lu_we = 1'b1;
            if (k_q == i_q) begin
              diag_we = 1'b1;
              if (fin_val == '0) begin
                sing_d  = 1'b1;
                e_d     = '0;
                state_d = S_OUT;
              end else begin
                state_d = S_NEXT;
              end
            end else begin
              state_d = S_NEXT;
            end
          end
          K_FWD: begin
            vec_we  = 1'b1;
            state_d = S_NEXT;
          end
          default: state_d = S_DIV;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (kind_q == K_LO) begin
            lu_we = 1'b1;
            lu_wa = mat_addr(k_q, i_q);
            lu_wd = div_rsp.quot;
          end else begin
            vec_we = 1'b1;
            vec_wd = div_rsp.quot;
          end
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        state_d = S_START;
        case (kind_q)
          K_UP: begin
            if ((k_q + NW'(1)) < n_q) begin
              k_d = k_q + NW'(1);
            end else if ((i_q + NW'(1)) < n_q) begin
              kind_d = K_LO;
              k_d    = i_q + NW'(1);
            end else begin
              kind_d = K_FWD;
              i_d    = '0;
            end
          end
          K_LO: begin
            if ((k_q + NW'(1)) < n_q) begin
              k_d = k_q + NW'(1);
            end else begin
              kind_d = K_UP;
              i_d    = i_q + NW'(1);
              k_d    = i_q + NW'(1);
            end
          end
          K_FWD: begin
            if ((i_q + NW'(1)) < n_q) begin
              i_d = i_q + NW'(1);
            end else begin
              kind_d = K_BWD;
              i_d    = n_q - NW'(1);
            end
          end
          default: begin
            if (i_q == '0) begin
              e_d     = '0;
              state_d = S_OUT;
            end else begin
              i_d = i_q - NW'(1);
            end
          end
        endcase
      end
      S_OUT: begin
        if (out_o.ready) begin
          if (e_q == (n_q - NW'(1))) begin
            state_d = S_IDLE;
          end else begin
            e_d = e_q + NW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_UP;
      i_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      n_q     <= NW'(1);
      e_q     <= '0;
      sing_q  <= 1'b0;
      size_q  <= 4'd3;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      i_q     <= i_d;
      k_q     <= k_d;
      j_q     <= j_d;
      n_q     <= n_d;
      e_q     <= e_d;
      sing_q  <= sing_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // coefficient store: load writes, one registered read
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_i.operation == OP_LOAD_COEF) && (32'(in_i.row) < MAX_DIM) &&
        (32'(in_i.column) < MAX_DIM)) begin
      coef_mem[mat_addr(NW'(in_i.row), NW'(in_i.column))] <= in_i.element_value;
    end
    coef_rd_q <= coef_mem[coef_ra];
  end

  // combined l and u store: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (lu_we) begin
      lu_mem[lu_wa] <= lu_wd;
    end
    lu_a_q <= lu_mem[lu_ra];
    lu_b_q <= lu_mem[lu_rb];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (in_i.operation == OP_LOAD_RHS) && (32'(in_i.row) < MAX_DIM)) begin
      rhs_r[IW'(in_i.row)] <= in_i.element_value;
    end
    if (vec_we) begin
      vec_r[IW'(i_q)] <= vec_wd;
    end
    if (diag_we) begin
      diag_r[IW'(i_q)] <= fin_val;
    end
  end

  assign out_o.valid          = (state_q == S_OUT);
  assign out_o.solution_index = e_q[2:0];
  assign out_o.solution_value = sing_q ? '0 : vec_r[IW'(e_q)];
  assign out_o.singular       = sing_q;
  assign out_o.last_result    = (e_q == (n_q - NW'(1)));
endmodule
`default_nettype wire

// ----- rtl/lu_checker.sv -----
// port-level checks of the lu solver, bound to the top level
// depends on lu_linear_solver_assert.svh
`default_nettype none
`include "lu_linear_solver_assert.svh"
module lu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  out_index_i,
  input wire logic [31:0] out_value_i,
  input wire logic        out_singular_i,
  input wire logic        out_last_i
);
  logic out_beat;
  assign out_beat = out_valid_i && out_ready_i;

  `LU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_index_i) && $stable(out_value_i))
  `LU_ASSERT_NOW(a_busy_emit, clk_i, rst_ni, out_valid_i, !in_ready_i)
  `LU_ASSERT_NOW(a_sing_zero, clk_i, rst_ni, out_valid_i && out_singular_i, out_value_i == 32'h0)
  `LU_ASSERT_NEXT(a_next_index, clk_i, rst_ni, out_beat && !out_last_i, out_valid_i && (out_index_i == $past(out_index_i) + 3'd1))
  `LU_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, out_beat && out_last_i, !out_valid_i && in_ready_i)
endmodule

bind lu_linear_solver lu_checker u_lu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_index_i    (out_o.solution_index),
  .out_value_i    (out_o.solution_value),
  .out_singular_i (out_o.singular),
  .out_last_i     (out_o.last_result)
);
`default_nettype wire
